// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define HRC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrc check failed");

// The expression must never be true out of reset.
`define HRC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("hrc check failed");

`endif

// ===== sv/hrc_pkg.sv =====
// Shared types, constants and the hex digit decoder for the RGB to CMYK block.
// No dependencies; every module imports this package.
`default_nettype none

package hrc_pkg;

  // Number of output steps per share (ten gives tenths)
  localparam int OUTPUT_STEPS = 10;
  localparam int FULL_SCALE   = 255;

  localparam int CHAN_W  = 8;
  localparam int SHARE_W = 4;
  localparam int QUOT_W  = $clog2(OUTPUT_STEPS + 1);
  localparam int NUM_W   = CHAN_W + QUOT_W;
  localparam int CHARS   = 6;
  localparam int LANES   = 4;

  // Cycles from accepted item to result strobe
  localparam int PIPE_LAT = QUOT_W + 3;

  // Lane order
  localparam int LANE_C = 0;
  localparam int LANE_M = 1;
  localparam int LANE_Y = 2;
  localparam int LANE_K = 3;

  // ASCII codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;

  typedef logic [7:0]         char_t;
  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [QUOT_W-1:0]  quot_t;
  typedef logic [SHARE_W-1:0] share_t;

  typedef struct packed {
    logic ok;
    logic [3:0] val;
  } nib_t;

  // Sideband that travels alongside the divider lanes
  typedef struct packed {
    logic valid;
    logic bad;
    logic black;
  } ctl_t;

  // Decode one ASCII hex digit, either case
  function automatic nib_t hex_decode(input char_t ch);
    nib_t res;
    res.ok  = 1'b1;
    res.val = 4'd0;
    if (ch >= CH_0 && ch <= CH_9) begin
      res.val = 4'(ch - CH_0);
    end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
      res.val = 4'(ch - CH_UP_A + 8'd10);
    end else if (ch >= CH_LOW_A && ch <= CH_LOW_F) begin
      res.val = 4'(ch - CH_LOW_A + 8'd10);
    end else begin
      res.ok = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hex_rgb_to_cmyk_tenths.sv =====
// Top level of the hex RGB to CMYK converter.
// Depends on hrc_pkg, hrc_front, hrc_div_lane and hrc_merge.
//
// Takes one colour as six ASCII hex digits (RRGGBB, either case) on every
// clock at which start is high; busy is always low, so an item can be
// offered each cycle. Each item gives exactly one result, shown for one
// cycle with out_valid high; results come in input order and cannot be
// held off. The pipeline is made of four parallel restoring divider
// lanes that resolve one quotient bit per pipeline stage, plus a decode
// stage, an operand stage and the output register. A non-hex character
// sets out_bad_digit with all shares zero; black gives key at full scale.
`default_nettype none

module hex_rgb_to_cmyk_tenths import hrc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  char_t  in_red_high_char,
  input  char_t  in_red_low_char,
  input  char_t  in_green_high_char,
  input  char_t  in_green_low_char,
  input  char_t  in_blue_high_char,
  input  char_t  in_blue_low_char,
  output logic   out_valid,
  output share_t out_cyan_tenths,
  output share_t out_magenta_tenths,
  output share_t out_yellow_tenths,
  output share_t out_key_tenths,
  output logic   out_bad_digit
);

  char_t [CHARS-1:0] chars;
  ctl_t              ctl;
  num_t  [LANES-1:0] num;
  chan_t [LANES-1:0] den;
  quot_t [LANES-1:0] quot;
  logic              accept;

  // Fully pipelined: never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign chars = {in_blue_low_char, in_blue_high_char,
                  in_green_low_char, in_green_high_char,
                  in_red_low_char, in_red_high_char};

  hrc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .chars  (chars),
    .ctl_o  (ctl),
    .num_o  (num),
    .den_o  (den)
  );

  // One divider lane per CMYK share
  genvar l;
  for (l = 0; l < LANES; l++) begin : g_lane
    hrc_div_lane u_lane (
      .clk    (clk),
      .num_i  (num[l]),
      .den_i  (den[l]),
      .quot_o (quot[l])
    );
  end

  hrc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl),
    .quot_i    (quot),
    .valid_o   (out_valid),
    .cyan_o    (out_cyan_tenths),
    .magenta_o (out_magenta_tenths),
    .yellow_o  (out_yellow_tenths),
    .key_o     (out_key_tenths),
    .bad_o     (out_bad_digit)
  );

endmodule

`default_nettype wire

// ===== sv/hrc_front.sv =====
// Front end: hex digit decode, channel max and divider operands (two stages).
// Depends on hrc_pkg.
`default_nettype none

module hrc_front import hrc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  char_t [CHARS-1:0]      chars,
  output ctl_t                   ctl_o,
  output num_t  [LANES-1:0]      num_o,
  output chan_t [LANES-1:0]      den_o
);

  ctl_t              ctl_a_r, ctl_a_nxt;
  chan_t [2:0]       rgb_a_r, rgb_a_nxt;
  ctl_t              ctl_b_r, ctl_b_nxt;
  num_t  [LANES-1:0] num_b_r, num_b_nxt;
  chan_t [LANES-1:0] den_b_r, den_b_nxt;
  chan_t             mx;
  nib_t  [CHARS-1:0] nib;

  // Stage A: decode the six digits
  always_comb begin
    ctl_a_nxt.valid = accept;
    ctl_a_nxt.bad   = 1'b0;
    ctl_a_nxt.black = 1'b0;
    for (int i = 0; i < CHARS; i++) begin
      nib[i] = hex_decode(chars[i]);
      if (!nib[i].ok) begin
        ctl_a_nxt.bad = 1'b1;
      end
    end
    for (int c = 0; c < 3; c++) begin
      rgb_a_nxt[c] = {nib[2*c].val, nib[2*c+1].val};
    end
  end

  // Stage B: max channel, numerators scaled by the step count
  always_comb begin
    mx = rgb_a_r[0];
    if (rgb_a_r[1] > mx) begin
      mx = rgb_a_r[1];
    end
    if (rgb_a_r[2] > mx) begin
      mx = rgb_a_r[2];
    end
    ctl_b_nxt       = ctl_a_r;
    ctl_b_nxt.black = (mx == '0);
    for (int c = 0; c < 3; c++) begin
      num_b_nxt[c] = NUM_W'(OUTPUT_STEPS) * NUM_W'(mx - rgb_a_r[c]);
      den_b_nxt[c] = mx;
    end
    num_b_nxt[LANE_K] = NUM_W'(OUTPUT_STEPS) * NUM_W'(CHAN_W'(FULL_SCALE) - mx);
    den_b_nxt[LANE_K] = CHAN_W'(FULL_SCALE);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else begin
      ctl_a_r <= ctl_a_nxt;
      ctl_b_r <= ctl_b_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rgb_a_r <= rgb_a_nxt;
    num_b_r <= num_b_nxt;
    den_b_r <= den_b_nxt;
  end

  assign ctl_o = ctl_b_r;
  assign num_o = num_b_r;
  assign den_o = den_b_r;

endmodule

`default_nettype wire

// ===== sv/hrc_div_lane.sv =====
// One divider lane: restoring division, one quotient bit per pipeline stage.
// Depends on hrc_pkg; the quotient is known to fit in QUOT_W bits.
`default_nettype none

module hrc_div_lane import hrc_pkg::*; (
  input  logic  clk,
  input  num_t  num_i,
  input  chan_t den_i,
  output quot_t quot_o
);

  num_t  rem_r [QUOT_W];
  num_t  rem_nxt [QUOT_W];
  chan_t den_r [QUOT_W];
  quot_t q_r [QUOT_W];
  quot_t q_nxt [QUOT_W];

  genvar k;
  for (k = 0; k < QUOT_W; k++) begin : g_step
    localparam int Bit = QUOT_W - 1 - k;
    num_t  rem_in;
    chan_t den_in;
    quot_t q_in;
    num_t  trial;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign trial = num_t'(den_in) << Bit;

    // Trial subtract of the shifted divisor
    always_comb begin
      q_nxt[k] = q_in;
      if (rem_in >= trial) begin
        rem_nxt[k]    = rem_in - trial;
        q_nxt[k][Bit] = 1'b1;
      end else begin
        rem_nxt[k] = rem_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt[k];
      den_r[k] <= den_in;
      q_r[k]   <= q_nxt[k];
    end
  end

  assign quot_o = q_r[QUOT_W-1];

endmodule

`default_nettype wire

// ===== sv/hrc_merge.sv =====
// Merge stage: aligns the sideband with the lanes, applies the bad digit and
// black cases and registers the result. Depends on hrc_pkg.
`default_nettype none

module hrc_merge import hrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl_i,
  input  quot_t [LANES-1:0] quot_i,
  output logic              valid_o,
  output share_t            cyan_o,
  output share_t            magenta_o,
  output share_t            yellow_o,
  output share_t            key_o,
  output logic              bad_o
);

  ctl_t   ctl_r [QUOT_W];
  logic   valid_r;
  logic   bad_r, bad_nxt;
  share_t [LANES-1:0] share_r, share_nxt;
  ctl_t   ctl_d;

  // Sideband delay matching the divider depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QUOT_W; k++) begin
        ctl_r[k] <= '0;
      end
      valid_r <= 1'b0;
    end else begin
      ctl_r[0] <= ctl_i;
      for (int k = 1; k < QUOT_W; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
      valid_r <= ctl_d.valid;
    end
  end

  assign ctl_d = ctl_r[QUOT_W-1];

  // Special cases override the lane quotients
  always_comb begin
    bad_nxt = ctl_d.bad;
    for (int l = 0; l < LANES; l++) begin
      share_nxt[l] = SHARE_W'(quot_i[l]);
    end
    if (ctl_d.bad) begin
      share_nxt = '0;
    end else if (ctl_d.black) begin
      share_nxt         = '0;
      share_nxt[LANE_K] = SHARE_W'(OUTPUT_STEPS);
    end
  end

  always_ff @(posedge clk) begin
    bad_r   <= bad_nxt;
    share_r <= share_nxt;
  end

  assign valid_o   = valid_r;
  assign bad_o     = bad_r;
  assign cyan_o    = share_r[LANE_C];
  assign magenta_o = share_r[LANE_M];
  assign yellow_o  = share_r[LANE_Y];
  assign key_o     = share_r[LANE_K];

endmodule

`default_nettype wire

// ===== sv/hrc_checker.sv =====
// Port-level checks for hex_rgb_to_cmyk_tenths, bound to the top level.
// Depends on hrc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hrc_checker import hrc_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   start,
  input logic   busy,
  input logic   out_valid,
  input share_t out_cyan_tenths,
  input share_t out_magenta_tenths,
  input share_t out_yellow_tenths,
  input share_t out_key_tenths,
  input logic   out_bad_digit
);

  // The pipeline never pushes back
  `HRC_ASSERT_NEVER(a_never_busy, busy)

  // Every result traces back to an item taken a fixed latency earlier
  `HRC_ASSERT_IMPLY(a_result_has_item, out_valid, $past(start && !busy, PIPE_LAT))

  // A bad digit zeroes every share
  `HRC_ASSERT_IMPLY(a_bad_zeroes, out_valid && out_bad_digit, out_cyan_tenths == '0 && out_magenta_tenths == '0 && out_yellow_tenths == '0 && out_key_tenths == '0)

  // The largest channel always maps to a zero share
  `HRC_ASSERT_IMPLY(a_max_lane_zero, out_valid && !out_bad_digit, out_cyan_tenths == '0 || out_magenta_tenths == '0 || out_yellow_tenths == '0)

endmodule

bind hex_rgb_to_cmyk_tenths hrc_checker u_hrc_checker (.*);

`default_nettype wire
